@@ design/ssr_pkg.sv @@
// ---------------------------------------------------------------------------
// ssr_pkg
// shared constants and controller/datapath interface types for the score sorter
// ---------------------------------------------------------------------------
package ssr_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SCORE_W     = 9;
  localparam int IDX_W       = 6;
  localparam int RANK_W      = 7;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  typedef struct packed {
    logic             insert;
    logic             pop;
    logic             final_pop;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] pos;
  } ssr_ctrl_t;

  typedef struct packed {
    logic out_free;
  } ssr_stat_t;

endpackage

@@ design/ssr_ctrl.sv @@
// ---------------------------------------------------------------------------
// ssr_ctrl
// load / drain sequencer: counts entries in, then steps the sorted row out
// ---------------------------------------------------------------------------
module ssr_ctrl
  import ssr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_axis_tvalid,
  input  logic      s_axis_tlast,
  output logic      s_axis_tready,
  input  ssr_stat_t stat,
  output ssr_ctrl_t ctl
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] pos_inc;
  logic             set_end;

  assign count_inc = count + CNT_W'(1);
  assign pos_inc   = pos + CNT_W'(1);
  assign set_end   = s_axis_tlast || (count_inc == CNT_W'(MAX_ENTRIES));

  always_comb begin
    s_axis_tready = 1'b0;
    ctl.insert    = 1'b0;
    ctl.pop       = 1'b0;
    ctl.final_pop = 1'b0;
    case (state)
      ST_LOAD: begin
        s_axis_tready = 1'b1;
        ctl.insert    = s_axis_tvalid;
      end
      ST_DRAIN: begin
        ctl.pop       = stat.out_free;
        ctl.final_pop = stat.out_free && (pos_inc == count);
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
    ctl.count = count;
    ctl.pos   = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      pos   <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (ctl.insert) begin
            count <= count_inc;
            pos   <= '0;
            if (set_end) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (ctl.final_pop) begin
            state <= ST_LOAD;
            count <= '0;
            pos   <= '0;
          end else if (ctl.pop) begin
            pos <= pos_inc;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

@@ design/ssr_datapath.sv @@
// ---------------------------------------------------------------------------
// ssr_datapath
// insertion-sorting row of cells, shift-out path, rank and output register
// ---------------------------------------------------------------------------
module ssr_datapath
  import ssr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ssr_ctrl_t             ctl,
  output ssr_stat_t             stat,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // score
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // entry_index, sorted_score, rank
  output logic                  m_axis_tlast    // final_res
);

  logic [SCORE_W-1:0] cell_score [MAX_ENTRIES];
  logic [IDX_W-1:0]   cell_idx   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt;

  logic [SCORE_W-1:0] score_in;
  logic [IDX_W-1:0]   idx_in;

  logic               out_valid;
  logic [IDX_W-1:0]   out_idx;
  logic [SCORE_W-1:0] out_score;
  logic [RANK_W-1:0]  out_rank;
  logic               out_last;
  logic [RANK_W-1:0]  rank_next;
  logic [CNT_W-1:0]   pos_inc;

  assign score_in = s_axis_tdata[SCORE_W-1:0];
  assign idx_in   = ctl.count[IDX_W-1:0];

  // empty cells count as smaller than any incoming score
  always_comb begin
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      lt[k] = (CNT_W'(k) >= ctl.count) || (cell_score[k] < score_in);
    end
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    always_ff @(posedge clk) begin
      if (ctl.insert && lt[k]) begin
        if (k == 0) begin
          cell_score[k] <= score_in;
          cell_idx[k]   <= idx_in;
        end else if (lt[(k == 0) ? 0 : k-1]) begin
          cell_score[k] <= cell_score[(k == 0) ? 0 : k-1];
          cell_idx[k]   <= cell_idx[(k == 0) ? 0 : k-1];
        end else begin
          cell_score[k] <= score_in;
          cell_idx[k]   <= idx_in;
        end
      end else if (ctl.pop && (k < MAX_ENTRIES-1)) begin
        cell_score[k] <= cell_score[(k < MAX_ENTRIES-1) ? k+1 : k];
        cell_idx[k]   <= cell_idx[(k < MAX_ENTRIES-1) ? k+1 : k];
      end
    end
  end

  // ties keep the rank of the first entry with that score
  assign pos_inc   = ctl.pos + CNT_W'(1);
  assign rank_next = ((ctl.pos == '0) || (cell_score[0] != out_score)) ?
                     RANK_W'(pos_inc) : out_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.pop) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      out_idx   <= cell_idx[0];
      out_score <= cell_score[0];
      out_rank  <= rank_next;
      out_last  <= ctl.final_pop;
    end
  end

  assign stat.out_free = !out_valid || m_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W - IDX_W - SCORE_W - RANK_W)'(0),
                          out_rank, out_score, out_idx};
  assign m_axis_tlast  = out_last;

endmodule

@@ design/score_sort_and_rank_top.sv @@
// ---------------------------------------------------------------------------
// score_sort_and_rank_top
// stable descending score sort with competition ranking
// ---------------------------------------------------------------------------
// Scores arrive on the slave stream, one per transfer, tlast closing the set.
// A set also closes on the transfer that fills all MAX_ENTRIES cells.
// Each transfer is inserted into a row of compare-and-shift cells, with tready
// held high throughout loading. Once the set is closed, tready drops and the
// row is shifted out from its head, one result per cycle while the master
// side accepts: arrival index, score and competition rank, tlast on the last
// result. After the closing transfer the controller enters its drain state,
// and the first result is then taken into the output register. The output
// register lets the next set start loading while the final result of the
// previous set still waits.
// A stall on the master side holds the output register and pauses the
// drain; nothing is lost or repeated.
// Reset empties the row and returns to loading; cell contents are not
// cleared, only the fill count, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module score_sort_and_rank_top
  import ssr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // score
  input  logic                  s_axis_tlast,   // last
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // entry_index, sorted_score, rank
  output logic                  m_axis_tlast    // final_res
);

  ssr_ctrl_t ctl;
  ssr_stat_t stat;

  ssr_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .ctl           (ctl)
  );

  ssr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // a stalled result holds its data until the transfer
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // loading and draining never overlap
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !ctl.pop)
    else $error("pop while loading");

  // fill count within capacity, drain position inside the set
  assert property (@(posedge clk) disable iff (rst)
    (ctl.count <= CNT_W'(MAX_ENTRIES)) && ((ctl.pos == '0) || (ctl.pos < ctl.count)))
    else $error("count or position out of range");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// checks the score sorter against its own ranking model
// ---------------------------------------------------------------------------
// Score sets are queued up front and streamed in with random gaps. Every
// accepted score goes into a sorted row kept by the testbench. When a set
// closes, on tlast or on the transfer that fills the row, the row yields the
// expected ranked results. The monitor stalls at random and compares each
// result transfer field by field. Once the receiver holds off long enough
// for the block to stall its input, and some sets wait for a full drain.
// ---------------------------------------------------------------------------
module testbench;
  import ssr_pkg::*;

  localparam int STALL_MAX   = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 20;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic               last;
    int                 gap;
    logic               drain;
  } score_item_t;

  typedef struct {
    logic [IDX_W-1:0]   idx;
    logic [SCORE_W-1:0] score;
    logic [RANK_W-1:0]  rank;
    logic               fin;
  } ranked_t;

  logic                  clk     = 1'b0;
  logic                  rst     = 1'b1;
  logic                  s_valid = 1'b0;
  logic [IN_DATA_W-1:0]  s_data  = '0;   // score
  logic                  s_last  = 1'b0; // last
  logic                  s_axis_tready;
  logic                  m_axis_tvalid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // entry_index, sorted_score, rank
  logic                  m_axis_tlast;   // final_res

  score_item_t        pend_q[$];
  ranked_t            ranked_q[$];
  logic [SCORE_W-1:0] row_score [MAX_ENTRIES];
  logic [IDX_W-1:0]   row_idx   [MAX_ENTRIES];
  int                 row_fill = 0;
  int                 idle_cnt = 0;
  int                 stall_left = 0;
  int                 rx_mode = 0;
  int                 out_cnt = 0;
  int                 hold_left = 0;
  logic               hold_done = 1'b0;
  int                 quiet = 0;
  int                 errors = 0;

  always #5 clk = ~clk;

  score_sort_and_rank_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // insert behind equal scores, emit the ranked row when the set closes
  task automatic rank_insert(input logic [SCORE_W-1:0] sc, input logic lst);
    int      p;
    int      first;
    ranked_t r;
    p = row_fill;
    while (p > 0 && row_score[p-1] < sc) begin
      row_score[p] = row_score[p-1];
      row_idx[p]   = row_idx[p-1];
      p--;
    end
    row_score[p] = sc;
    row_idx[p]   = row_fill[IDX_W-1:0];
    row_fill++;
    if (lst || row_fill == MAX_ENTRIES) begin
      first = 0;
      for (int k = 0; k < row_fill; k++) begin
        if (k == 0 || row_score[k] != row_score[k-1]) first = k;
        r.idx   = row_idx[k];
        r.score = row_score[k];
        r.rank  = RANK_W'(first + 1);
        r.fin   = (k + 1 == row_fill);
        ranked_q.push_back(r);
      end
      row_fill = 0;
    end
  endtask

  task automatic note_mismatch(input string what, input int expv, input int gotv);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", what, expv, gotv);
  endtask

  task automatic add_item(input int sc, input logic lst, input int gap, input logic drain);
    score_item_t it;
    it.score = SCORE_W'(sc);
    it.last  = lst;
    it.gap   = gap;
    it.drain = drain;
    pend_q.push_back(it);
  endtask

  // one set of random scores; forced sets fill the row and never raise last
  task automatic add_set(input int n, input logic forced, input logic drain);
    int score_mode;
    int gap_mode;
    int base;
    int sc;
    int gap;
    score_mode = $urandom_range(0, 2);
    gap_mode   = $urandom_range(0, 2);
    base       = $urandom_range(0, 508);
    for (int k = 0; k < n; k++) begin
      case (score_mode)
        0: sc = $urandom_range(0, 511);
        1: sc = $urandom_range(0, 300);
        default: sc = base + $urandom_range(0, 3);
      endcase
      case (gap_mode)
        0: gap = 0;
        1: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, STALL_MAX) : 0;
        default: gap = $urandom_range(0, STALL_MAX);
      endcase
      add_item(sc, !forced && (k == n - 1), gap, drain && (k == 0));
    end
  endtask

  // sender
  always @(posedge clk) begin
    score_item_t cur;
    logic        took;
    logic        give;
    if (rst) begin
      s_valid  <= 1'b0;
      idle_cnt = 0;
    end else begin
      took = s_valid && s_axis_tready;
      if (took) begin
        cur = pend_q.pop_front();
        rank_insert(cur.score, cur.last);
        idle_cnt = 0;
      end else if (!s_valid) begin
        idle_cnt++;
      end
      if (s_valid && !took) begin
        give = 1'b1;
      end else begin
        give = pend_q.size() != 0 && idle_cnt >= pend_q[0].gap &&
               !(pend_q[0].drain && ranked_q.size() != 0);
      end
      s_valid <= give;
      if (give) begin
        s_data <= {{(IN_DATA_W-SCORE_W){1'b0}}, pend_q[0].score};
        s_last <= pend_q[0].last;
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    ranked_t e;
    if (rst) begin
      m_ready    <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_ready) begin
        if (ranked_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: index %0d score %0d",
                     m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W +: SCORE_W]);
        end else begin
          e = ranked_q.pop_front();
          if (m_axis_tdata[IDX_W-1:0] != e.idx)
            note_mismatch("entry_index", e.idx, m_axis_tdata[IDX_W-1:0]);
          if (m_axis_tdata[IDX_W +: SCORE_W] != e.score)
            note_mismatch("sorted_score", e.score, m_axis_tdata[IDX_W +: SCORE_W]);
          if (m_axis_tdata[IDX_W+SCORE_W +: RANK_W] != e.rank)
            note_mismatch("rank", e.rank, m_axis_tdata[IDX_W+SCORE_W +: RANK_W]);
          if (m_axis_tlast != e.fin)
            note_mismatch("final_res", e.fin, m_axis_tlast);
        end
        if (out_cnt % 24 == 23) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
          0: stall_left = 0;
          1: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, STALL_MAX) : 0;
          default: stall_left = $urandom_range(0, STALL_MAX);
        endcase
        out_cnt <= out_cnt + 1;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      m_ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // one long receiver hold-off, early in the random part
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && out_cnt >= 30) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int si;
    // single-entry sets at both ends of the range
    add_item(0, 1'b1, 0, 1'b0);
    add_item(511, 1'b1, 2, 1'b0);
    // mixed set with ties and both extreme values
    add_item(300, 1'b0, 0, 1'b0);
    add_item(0, 1'b0, 1, 1'b0);
    add_item(511, 1'b0, 0, 1'b0);
    add_item(300, 1'b0, 0, 1'b0);
    add_item(300, 1'b0, 3, 1'b0);
    add_item(1, 1'b1, 0, 1'b0);
    // all equal
    repeat (3) add_item(5, 1'b0, 0, 1'b0);
    add_item(5, 1'b1, 0, 1'b0);
    // ascending, each new one to the head
    add_item(1, 1'b0, 0, 1'b1);
    add_item(2, 1'b0, 0, 1'b0);
    add_item(3, 1'b0, 0, 1'b0);
    add_item(4, 1'b1, 0, 1'b0);
    // descending, each new one to the tail
    add_item(256, 1'b0, 0, 1'b0);
    add_item(128, 1'b0, 0, 1'b0);
    add_item(64, 1'b0, 0, 1'b0);
    add_item(32, 1'b0, 0, 1'b0);
    add_item(16, 1'b1, 0, 1'b0);

    si = 0;
    while (pend_q.size() < 180) begin
      if (si == 5)
        add_set(MAX_ENTRIES, 1'b1, 1'b0);
      else if ($urandom_range(0, 7) == 0)
        add_set($urandom_range(13, 40), 1'b0, si % 4 == 3);
      else
        add_set($urandom_range(1, 12), 1'b0, si % 4 == 3);
      si++;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || ranked_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
